// File: design/lsh_pkg.sv
// shared types, constants and helpers for the hyperplane lsh signature block
package lsh_pkg;

  localparam int MAX_PLANES = 64;
  localparam int MAX_DIM    = 1024;

  localparam int PLANE_W    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int COEF_DEPTH = MAX_PLANES * MAX_DIM;
  localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

  localparam int OPCODE_W   = 2;
  localparam int PIDX_W     = 6;
  localparam int EIDX_W     = 10;
  localparam int VALUE_W    = 16;
  localparam int SIG_W      = 64;
  localparam int CNT_W      = 32;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int NPL_W      = 7;
  localparam int NDIM_W     = 11;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  // result kinds
  localparam logic KIND_SIG = 1'b0;
  localparam logic KIND_CNT = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_PLANES = 1'b0;
  localparam logic REG_DIMS   = 1'b1;

  localparam logic [NPL_W-1:0]  PLANES_RST = 7'd64;
  localparam logic [NDIM_W-1:0] DIMS_RST   = 11'd128;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]        CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic               load;       // write one coefficient from the input beat
    logic               capture;    // latch element index and value of a query beat
    logic               mac_issue;  // read coefficient and accumulator of one plane
    logic               sgn_issue;  // read accumulator and counters of one plane
    logic               cnt_issue;  // read counters for a counter read
    logic               cnt_zero;   // counter read of a plane that does not exist
    logic               emit_sig;   // present the signature, clear accumulators
    logic               emit_cnt;   // present the balance counts
    logic [PLANE_W-1:0] plane;
  } lsh_cmd_t;

  // flat coefficient address: plane major, element minor
  function automatic logic [COEF_AW-1:0] coef_addr(input int unsigned p, input int unsigned e);
    int unsigned a;
    a = p * MAX_DIM + e;
    return a[COEF_AW-1:0];
  endfunction

endpackage

// File: design/lsh_ctrl.sv
// controller state machine: sequences planes for accumulate, sign and counter read
module lsh_ctrl import lsh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [PIDX_W-1:0]   plane_index,
  input  logic [EIDX_W-1:0]   element_index,
  input  logic                last_element,
  input  logic [NPL_W-1:0]    planes_in_use,
  input  logic [NDIM_W-1:0]   dims_in_use,
  output lsh_cmd_t            cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAC   = 4'd1;
  localparam logic [3:0] S_MDR1  = 4'd2;
  localparam logic [3:0] S_MDR2  = 4'd3;
  localparam logic [3:0] S_SGN   = 4'd4;
  localparam logic [3:0] S_SWAIT = 4'd5;
  localparam logic [3:0] S_SEMIT = 4'd6;
  localparam logic [3:0] S_CRD   = 4'd7;
  localparam logic [3:0] S_CEMIT = 4'd8;

  logic [3:0]         state, state_next;
  logic [PLANE_W-1:0] plane, plane_next;
  logic               last_q, last_q_next;
  logic [PLANE_W-1:0] rd_plane, rd_plane_next;
  logic               rd_oob, rd_oob_next;

  logic [NPL_W-1:0]   np_c;
  logic [PLANE_W-1:0] np_m1;
  logic               elem_ok;
  logic               plane_ok;
  logic               accept;

  // clamp the active plane count to 1..MAX_PLANES
  always_comb begin
    if (planes_in_use == '0) begin
      np_c = NPL_W'(1);
    end else if (32'(planes_in_use) > 32'(MAX_PLANES)) begin
      np_c = NPL_W'(MAX_PLANES);
    end else begin
      np_c = planes_in_use;
    end
  end

  assign np_m1 = PLANE_W'(np_c - NPL_W'(1));

  // element within the active dimension (dims 0 acts as 1)
  always_comb begin
    if (dims_in_use == '0) begin
      elem_ok = (element_index == '0);
    end else begin
      elem_ok = (32'(element_index) < 32'(dims_in_use)) &&
                (32'(element_index) < 32'(MAX_DIM));
    end
  end

  assign plane_ok = (32'(plane_index) < 32'(MAX_PLANES)) &&
                    (32'(element_index) < 32'(MAX_DIM));
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;

  always_comb begin
    state_next    = state;
    plane_next    = plane;
    last_q_next   = last_q;
    rd_plane_next = rd_plane;
    rd_oob_next   = rd_oob;
    cmd           = '0;
    cmd.plane     = plane;
    unique case (state)
      S_IDLE: begin
        plane_next = '0;
        if (accept) begin
          unique case (opcode)
            OP_LOAD: begin
              cmd.load = plane_ok;
            end
            OP_QUERY: begin
              cmd.capture = 1'b1;
              last_q_next = last_element;
              if (elem_ok) begin
                state_next = S_MAC;
              end else if (last_element) begin
                state_next = S_SGN;
              end
            end
            OP_READ: begin
              rd_plane_next = PLANE_W'(plane_index);
              rd_oob_next   = (32'(plane_index) >= 32'(MAX_PLANES));
              state_next    = S_CRD;
            end
            default: begin
            end
          endcase
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (plane == np_m1) begin
          plane_next = '0;
          state_next = S_MDR1;
        end else begin
          plane_next = plane + PLANE_W'(1);
        end
      end
      S_MDR1: begin
        state_next = S_MDR2;
      end
      S_MDR2: begin
        state_next = last_q ? S_SGN : S_IDLE;
      end
      S_SGN: begin
        cmd.sgn_issue = 1'b1;
        if (plane == np_m1) begin
          plane_next = '0;
          state_next = S_SWAIT;
        end else begin
          plane_next = plane + PLANE_W'(1);
        end
      end
      S_SWAIT: begin
        state_next = S_SEMIT;
      end
      S_SEMIT: begin
        cmd.emit_sig = 1'b1;
        state_next   = S_IDLE;
      end
      S_CRD: begin
        cmd.cnt_issue = 1'b1;
        cmd.plane     = rd_plane;
        state_next    = S_CEMIT;
      end
      S_CEMIT: begin
        cmd.emit_cnt = 1'b1;
        cmd.cnt_zero = rd_oob;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      plane    <= '0;
      last_q   <= 1'b0;
      rd_plane <= '0;
      rd_oob   <= 1'b0;
    end else begin
      state    <= state_next;
      plane    <= plane_next;
      last_q   <= last_q_next;
      rd_plane <= rd_plane_next;
      rd_oob   <= rd_oob_next;
    end
  end

endmodule

// File: design/lsh_dp.sv
// datapath: coefficient memory, shared multiply-accumulate, accumulators, counters
module lsh_dp import lsh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  lsh_cmd_t                  cmd,
  input  logic [PIDX_W-1:0]         plane_index,
  input  logic [EIDX_W-1:0]         element_index,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      result_valid,
  output logic                      result_kind,
  output logic [SIG_W-1:0]          signature,
  output logic [CNT_W-1:0]          plus_count,
  output logic [CNT_W-1:0]          minus_count
);

  logic signed [VALUE_W-1:0] coef_mem [COEF_DEPTH];
  logic signed [ACC_W-1:0]   acc_mem  [MAX_PLANES];
  logic [CNT_W-1:0]          pos_mem  [MAX_PLANES];
  logic [CNT_W-1:0]          neg_mem  [MAX_PLANES];
  logic [MAX_PLANES-1:0]     acc_vld;
  logic [MAX_PLANES-1:0]     pos_vld;
  logic [MAX_PLANES-1:0]     neg_vld;

  logic [EIDX_W-1:0]         elem_q;
  logic signed [VALUE_W-1:0] val_q;

  // read stage
  logic                      s1_mac, s1_sgn;
  logic [PLANE_W-1:0]        s1_plane;
  logic signed [VALUE_W-1:0] coef_rd;
  logic signed [ACC_W-1:0]   acc_rd;
  logic                      acc_rd_vld;
  logic [CNT_W-1:0]          pos_rd, neg_rd;
  logic                      pos_rd_vld, neg_rd_vld;

  // product stage
  logic                      s2_mac;
  logic [PLANE_W-1:0]        s2_plane;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc2;

  logic signed [ACC_W-1:0]   acc_eff;
  logic [CNT_W-1:0]          pos_eff, neg_eff;
  logic signed [ACC_W:0]     sum;
  logic signed [ACC_W-1:0]   sum_sat;
  logic                      plane_pos;
  logic [SIG_W-1:0]          sig;

  assign acc_eff   = acc_rd_vld ? acc_rd : '0;
  assign pos_eff   = pos_rd_vld ? pos_rd : '0;
  assign neg_eff   = neg_rd_vld ? neg_rd : '0;
  assign plane_pos = (acc_eff > 0);

  assign sum = {acc2[ACC_W-1], acc2} + (ACC_W+1)'(prod);

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      elem_q <= element_index;
      val_q  <= value;
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coef_mem[coef_addr(32'(plane_index), 32'(element_index))] <= value;
    end
    coef_rd <= coef_mem[coef_addr(32'(cmd.plane), 32'(elem_q))];
  end

  // accumulator and counter reads
  always_ff @(posedge clk) begin
    acc_rd     <= acc_mem[cmd.plane];
    acc_rd_vld <= acc_vld[cmd.plane];
    pos_rd     <= pos_mem[cmd.plane];
    pos_rd_vld <= pos_vld[cmd.plane];
    neg_rd     <= neg_mem[cmd.plane];
    neg_rd_vld <= neg_vld[cmd.plane];
    s1_plane   <= cmd.plane;
    prod       <= coef_rd * val_q;
    acc2       <= acc_eff;
    s2_plane   <= s1_plane;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_mac <= 1'b0;
      s1_sgn <= 1'b0;
      s2_mac <= 1'b0;
    end else begin
      s1_mac <= cmd.mac_issue;
      s1_sgn <= cmd.sgn_issue;
      s2_mac <= s1_mac;
    end
  end

  // accumulator writes
  always_ff @(posedge clk) begin
    if (s2_mac) begin
      acc_mem[s2_plane] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit_sig) begin
      acc_vld <= '0;
    end else if (s2_mac) begin
      acc_vld[s2_plane] <= 1'b1;
    end
  end

  // balance counter updates
  always_ff @(posedge clk) begin
    if (s1_sgn && plane_pos) begin
      pos_mem[s1_plane] <= (pos_eff == CNT_MAX) ? pos_eff : pos_eff + CNT_W'(1);
    end
    if (s1_sgn && !plane_pos) begin
      neg_mem[s1_plane] <= (neg_eff == CNT_MAX) ? neg_eff : neg_eff + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_vld <= '0;
      neg_vld <= '0;
    end else if (s1_sgn) begin
      if (plane_pos) begin
        pos_vld[s1_plane] <= 1'b1;
      end else begin
        neg_vld[s1_plane] <= 1'b1;
      end
    end
  end

  // signature bits
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_sig) begin
      sig <= '0;
    end else if (s1_sgn && plane_pos) begin
      sig[s1_plane] <= 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_sig || cmd.emit_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sig) begin
      result_kind <= KIND_SIG;
      signature   <= sig;
      plus_count  <= '0;
      minus_count <= '0;
    end else if (cmd.emit_cnt) begin
      result_kind <= KIND_CNT;
      signature   <= '0;
      plus_count  <= cmd.cnt_zero ? '0 : pos_eff;
      minus_count <= cmd.cnt_zero ? '0 : neg_eff;
    end
  end

endmodule

// File: design/hyperplane_lsh_signature.sv
// top level of the hyperplane lsh signature block: register port, controller, datapath
//
// Random-hyperplane (simhash) signature engine. A beat is taken when start is
// high and busy is low. Coefficient loads (opcode 0) are written in the accept
// cycle and never raise busy. A query element (opcode 1) inside the active
// dimension runs one shared 16x16 multiply-accumulate over every active plane,
// one plane per cycle; the beat holds busy through the pass and through
// S_MDR1 and S_MDR2, so the next element starts only after all of that. An
// element beyond dims_in_use skips the pass and, unless marked last, leaves
// busy low. On an element marked last a sign pass walks the planes again, one
// per cycle, then S_SWAIT and S_SEMIT, after which the signature beat leaves
// the result registers and the accumulators are cleared at once. A counter
// read (opcode 2) answers after S_CRD and S_CEMIT. Every result is a
// single-cycle beat marked by result_valid with no back pressure, so the
// receiver must take it in that cycle. Accumulators saturate at 48-bit signed
// limits, balance counters at all ones. The coefficient memory is not cleared
// by reset; a query over coefficients never loaded gives an undefined
// signature. Registers: planes_in_use at byte 0 (reset 64), dims_in_use at
// byte 4 (reset 128); write them only while busy is low and no result is due.
module hyperplane_lsh_signature import lsh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  // command beat
  input  logic                      start,
  output logic                      busy,
  input  logic [OPCODE_W-1:0]       opcode,
  input  logic [PIDX_W-1:0]         plane_index,
  input  logic [EIDX_W-1:0]         element_index,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last_element,
  // result beat
  output logic                      result_valid,
  output logic                      result_kind,
  output logic [SIG_W-1:0]          signature,
  output logic [CNT_W-1:0]          plus_count,
  output logic [CNT_W-1:0]          minus_count
);

  logic [NPL_W-1:0]  planes_in_use;
  logic [NDIM_W-1:0] dims_in_use;
  logic              reg_wr;
  lsh_cmd_t          cmd;

  // register file: word select on paddr[2], low address bits ignored
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      planes_in_use <= PLANES_RST;
      dims_in_use   <= DIMS_RST;
    end else if (reg_wr) begin
      unique case (paddr[2])
        REG_PLANES: planes_in_use <= pwdata[NPL_W-1:0];
        REG_DIMS:   dims_in_use   <= pwdata[NDIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PLANES: prdata = PDATA_W'(planes_in_use);
      REG_DIMS:   prdata = PDATA_W'(dims_in_use);
      default:    prdata = '0;
    endcase
  end

  // plane sequencing
  lsh_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .plane_index   (plane_index),
    .element_index (element_index),
    .last_element  (last_element),
    .planes_in_use (planes_in_use),
    .dims_in_use   (dims_in_use),
    .cmd           (cmd)
  );

  // memories, multiply-accumulate and result registers
  lsh_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .plane_index   (plane_index),
    .element_index (element_index),
    .value         (value),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .signature     (signature),
    .plus_count    (plus_count),
    .minus_count   (minus_count)
  );

endmodule

// File: tb/hyperplane_lsh_signature_checker.sv
`timescale 1ns / 1ps
// scoreboard for the hyperplane lsh signature block: predicts each result beat and compares it
module hyperplane_lsh_signature_checker import lsh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  input  logic                      start,
  input  logic                      busy,
  input  logic [OPCODE_W-1:0]       opcode,
  input  logic [PIDX_W-1:0]         plane_index,
  input  logic [EIDX_W-1:0]         element_index,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last_element,
  input  logic                      result_valid,
  input  logic                      result_kind,
  input  logic [SIG_W-1:0]          signature,
  input  logic [CNT_W-1:0]          plus_count,
  input  logic [CNT_W-1:0]          minus_count,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic             kind;
    logic [SIG_W-1:0] sig;
    logic [CNT_W-1:0] plus;
    logic [CNT_W-1:0] minus;
  } hash_result_t;

  logic signed [VALUE_W-1:0] coef_mem [COEF_DEPTH];
  logic signed [ACC_W-1:0]   plane_sum [MAX_PLANES];
  logic [CNT_W-1:0]          above_cnt [MAX_PLANES];
  logic [CNT_W-1:0]          below_cnt [MAX_PLANES];
  logic [NPL_W-1:0]          planes_reg;
  logic [NDIM_W-1:0]         dims_reg;
  hash_result_t              awaited_q [$];
  hash_result_t              got;
  hash_result_t              want;
  logic signed [PROD_W-1:0]  product;
  logic signed [ACC_W:0]     widened;
  int                        n_planes;
  int                        n_dims;
  int                        mismatches;

  task automatic compare_field(input string field, input logic [SIG_W-1:0] exp_v,
                               input logic [SIG_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", field, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      // the coefficient memory survives reset
      for (int p = 0; p < MAX_PLANES; p++) begin
        plane_sum[PLANE_W'(p)] = '0;
        above_cnt[PLANE_W'(p)] = '0;
        below_cnt[PLANE_W'(p)] = '0;
      end
      planes_reg = PLANES_RST;
      dims_reg   = DIMS_RST;
      awaited_q.delete();
    end else begin
      // a result beat always belongs to an earlier command, so check it first
      if (result_valid) begin
        got = {result_kind, signature, plus_count, minus_count};
        if (awaited_q.size() == 0) begin
          $error("result beat with no command awaiting one");
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          compare_field("result_kind", SIG_W'(want.kind), SIG_W'(got.kind));
          compare_field("signature", want.sig, got.sig);
          compare_field("plus_count", SIG_W'(want.plus), SIG_W'(got.plus));
          compare_field("minus_count", SIG_W'(want.minus), SIG_W'(got.minus));
        end
      end

      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_PLANES) begin
          planes_reg = pwdata[NPL_W-1:0];
        end else begin
          dims_reg = pwdata[NDIM_W-1:0];
        end
      end

      if (start && !busy) begin
        // out-of-range register values clamp to the legal span
        n_planes = (planes_reg == 0) ? 1 : (planes_reg > MAX_PLANES) ? MAX_PLANES : planes_reg;
        n_dims   = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIM) ? MAX_DIM : dims_reg;
        unique case (opcode)
          OP_LOAD: begin
            coef_mem[coef_addr(plane_index, element_index)] = value;
          end
          OP_QUERY: begin
            if (element_index < n_dims) begin
              for (int p = 0; p < n_planes; p++) begin
                product = coef_mem[coef_addr(p, element_index)] * value;
                widened = plane_sum[PLANE_W'(p)] + product;
                if (widened > ACC_MAX) begin
                  plane_sum[PLANE_W'(p)] = ACC_MAX;
                end else if (widened < ACC_MIN) begin
                  plane_sum[PLANE_W'(p)] = ACC_MIN;
                end else begin
                  plane_sum[PLANE_W'(p)] = widened[ACC_W-1:0];
                end
              end
            end
            if (last_element) begin
              want      = '0;
              want.kind = KIND_SIG;
              for (int p = 0; p < n_planes; p++) begin
                if (plane_sum[PLANE_W'(p)] > 0) begin
                  want.sig[PLANE_W'(p)] = 1'b1;
                  if (above_cnt[PLANE_W'(p)] != CNT_MAX) begin
                    above_cnt[PLANE_W'(p)] = above_cnt[PLANE_W'(p)] + CNT_W'(1);
                  end
                end else begin
                  if (below_cnt[PLANE_W'(p)] != CNT_MAX) begin
                    below_cnt[PLANE_W'(p)] = below_cnt[PLANE_W'(p)] + CNT_W'(1);
                  end
                end
              end
              for (int p = 0; p < MAX_PLANES; p++) plane_sum[PLANE_W'(p)] = '0;
              awaited_q = {awaited_q, want};
            end
          end
          OP_READ: begin
            want       = '0;
            want.kind  = KIND_CNT;
            want.plus  = above_cnt[plane_index];
            want.minus = below_cnt[plane_index];
            awaited_q = {awaited_q, want};
          end
          default: begin
          end
        endcase
      end
    end
    pending    <= awaited_q.size();
    fail_count <= mismatches;
  end

endmodule

// File: tb/hyperplane_lsh_signature_tb.sv
`timescale 1ns / 1ps
// testbench top for the hyperplane lsh signature block: clock, reset, stimulus and verdict
module hyperplane_lsh_signature_tb;
  import lsh_pkg::*;

  // the one opcode the block has no use for
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

  // worst busy stretch is an element followed by its sign pass over the planes
  localparam int SETTLE_CYCLES = 2 * MAX_PLANES + 16;
  localparam int DRAIN_LIMIT   = 8 * SETTLE_CYCLES;
  // length of the back-to-back single-plane stretch
  localparam int RUN_BEATS     = 24;
  localparam int RANDOM_ITEMS  = 500;
  localparam int PHASES        = 10;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      start;
  logic                      busy;
  logic [OPCODE_W-1:0]       opcode;
  logic [PIDX_W-1:0]         plane_index;
  logic [EIDX_W-1:0]         element_index;
  logic signed [VALUE_W-1:0] value;
  logic                      last_element;
  logic                      result_valid;
  logic                      result_kind;
  logic [SIG_W-1:0]          signature;
  logic [CNT_W-1:0]          plus_count;
  logic [CNT_W-1:0]          minus_count;

  int fail_count;
  int pending;

  // stimulus-side view of the block: which coefficients hold a value, and the
  // raw register contents, so that no query ever reads an unloaded coefficient
  bit               coef_loaded [MAX_PLANES][MAX_DIM];
  logic [NPL_W-1:0]  planes_now;
  logic [NDIM_W-1:0] dims_now;
  int                burst_left;
  int                items_done;
  bit                no_gaps;

  hyperplane_lsh_signature uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .plane_index   (plane_index),
    .element_index (element_index),
    .value         (value),
    .last_element  (last_element),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .signature     (signature),
    .plus_count    (plus_count),
    .minus_count   (minus_count)
  );

  hyperplane_lsh_signature_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .plane_index   (plane_index),
    .element_index (element_index),
    .value         (value),
    .last_element  (last_element),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .signature     (signature),
    .plus_count    (plus_count),
    .minus_count   (minus_count),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // active counts as the block sees them after clamping
  function automatic int live_planes();
    if (planes_now == 0) return 1;
    if (planes_now > MAX_PLANES) return MAX_PLANES;
    return planes_now;
  endfunction

  function automatic int live_dims();
    if (dims_now == 0) return 1;
    if (dims_now > MAX_DIM) return MAX_DIM;
    return dims_now;
  endfunction

  // mostly random, with the signed extremes, zero and minus one mixed in
  function automatic logic [VALUE_W-1:0] pick_value();
    unique case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // a handful of low positions keeps coefficient loads cheap; the top position
  // and the edge of the active range come up often, any position now and then
  function automatic logic [EIDX_W-1:0] pick_elem();
    int r;
    int border;
    r = $urandom_range(0, 99);
    if (r < 60) return EIDX_W'($urandom_range(0, 7));
    if (r < 70) return EIDX_W'(MAX_DIM - 1);
    if (r < 85) begin
      border = live_dims() - 1 + $urandom_range(0, 1);
      return EIDX_W'((border > MAX_DIM - 1) ? MAX_DIM - 1 : border);
    end
    return EIDX_W'($urandom_range(0, MAX_DIM - 1));
  endfunction

  // one command beat; start stays high on return so back-to-back beats need
  // no extra edge, and the burst/gap pattern decides when the sender rests
  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [PIDX_W-1:0] pl,
                           input logic [EIDX_W-1:0] el, input logic [VALUE_W-1:0] val,
                           input logic lst);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no rest at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    start         <= 1'b1;
    opcode        <= op;
    plane_index   <= pl;
    element_index <= el;
    value         <= val;
    last_element  <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_SPARE) items_done++;
  endtask

  // last_element means nothing on a load, so it is left random
  task automatic load_coef(input int pl, input int el, input logic [VALUE_W-1:0] c);
    send_beat(OP_LOAD, PIDX_W'(pl), EIDX_W'(el), c, 1'($urandom_range(0, 1)));
    coef_loaded[PLANE_W'(pl)][EIDX_W'(el)] = 1'b1;
  endtask

  // a query element inside the active range touches every active plane, so any
  // coefficient still missing at that position is loaded first
  task automatic send_element(input logic [EIDX_W-1:0] el, input logic [VALUE_W-1:0] x,
                              input logic lst);
    if (el < live_dims()) begin
      for (int p = 0; p < live_planes(); p++) begin
        if (!coef_loaded[PLANE_W'(p)][el]) load_coef(p, el, pick_value());
      end
    end
    send_beat(OP_QUERY, PIDX_W'($urandom), el, x, lst);
  endtask

  task automatic read_counts(input int pl);
    send_beat(OP_READ, PIDX_W'(pl), EIDX_W'($urandom), VALUE_W'($urandom),
              1'($urandom_range(0, 1)));
  endtask

  // hold the sender off until every predicted result beat has been seen or DRAIN_LIMIT runs out
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // setup cycle, then access cycle; the write lands when pready is seen high
  task automatic apb_write(input logic sel, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // both registers change only with the block idle; a non-last element gives
  // no result to wait for, so a settle time covers its multiply pass too.
  // upper data bits carry junk that the block must drop
  task automatic reconfigure(input logic [NPL_W-1:0] np, input logic [NDIM_W-1:0] nd);
    logic [PDATA_W-1:0] word;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    word = $urandom;
    word[NPL_W-1:0] = np;
    apb_write(REG_PLANES, word);
    word = $urandom;
    word[NDIM_W-1:0] = nd;
    apb_write(REG_DIMS, word);
    planes_now = np;
    dims_now   = nd;
  endtask

  initial begin
    int r;
    int len;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    start         = 1'b0;
    opcode        = OP_LOAD;
    plane_index   = '0;
    element_index = '0;
    value         = '0;
    last_element  = 1'b0;
    planes_now    = PLANES_RST;
    dims_now      = DIMS_RST;
    burst_left    = 0;
    items_done    = 0;
    no_gaps       = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: an element past the 128 active positions ends a vector
    // without reading any coefficient, so all 64 planes count non-positive
    read_counts(0);
    send_beat(OP_SPARE, '1, '1, '1, 1'b1);
    send_element(EIDX_W'(200), 16'h7FFF, 1'b1);
    read_counts(MAX_PLANES - 1);

    // three planes, full dimension; coefficient and element extremes at both ends
    reconfigure(NPL_W'(3), NDIM_W'(MAX_DIM));
    load_coef(0, 0, 16'h7FFF);
    load_coef(1, 0, 16'h8000);
    load_coef(2, 0, 16'h0000);
    load_coef(0, MAX_DIM - 1, 16'h8000);
    load_coef(1, MAX_DIM - 1, 16'h7FFF);
    load_coef(2, MAX_DIM - 1, 16'h0001);
    load_coef(MAX_PLANES - 1, MAX_DIM - 1, 16'h5A5A);
    send_element(EIDX_W'(0), 16'h7FFF, 1'b0);
    send_element(EIDX_W'(MAX_DIM - 1), 16'h8000, 1'b1);
    // an all-zero sum must give a clear bit
    send_element(EIDX_W'(0), 16'h0000, 1'b1);
    send_element(EIDX_W'(MAX_DIM - 1), 16'hFFFF, 1'b1);
    read_counts(0);
    read_counts(1);
    read_counts(2);

    // one plane, one position, most negative squared, fed back to back
    reconfigure(NPL_W'(1), NDIM_W'(1));
    load_coef(0, 0, 16'h8000);
    no_gaps = 1'b1;
    repeat (RUN_BEATS - 1) send_element(EIDX_W'(0), 16'h8000, 1'b0);
    send_element(EIDX_W'(0), 16'h8000, 1'b1);
    // position 1 is outside a one-wide range: an empty vector
    send_element(EIDX_W'(1), 16'h1234, 1'b1);
    read_counts(0);
    no_gaps = 1'b0;

    // random phases, each under its own register setting, extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      unique case (ph)
        0: reconfigure(NPL_W'(0), NDIM_W'(0));
        1: reconfigure(NPL_W'(MAX_PLANES), NDIM_W'(MAX_DIM));
        2: reconfigure(7'd127, 11'd2047);
        3: reconfigure(NPL_W'(1), NDIM_W'(8));
        4: reconfigure(NPL_W'(MAX_PLANES + 1), NDIM_W'(MAX_DIM + 1));
        default: reconfigure(NPL_W'($urandom_range(1, MAX_PLANES)),
                             NDIM_W'($urandom_range(1, 24)));
      endcase
      items_done = 0;
      while (items_done < RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          // a well-formed vector closed by a last mark
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
          for (int k = 0; k < len; k++) send_element(pick_elem(), pick_value(), k == len - 1);
        end else if (r < 70) begin
          load_coef($urandom_range(0, MAX_PLANES - 1), pick_elem(), pick_value());
        end else if (r < 85) begin
          read_counts($urandom_range(0, MAX_PLANES - 1));
        end else if (r < 90) begin
          send_beat(OP_SPARE, PIDX_W'($urandom), EIDX_W'($urandom), VALUE_W'($urandom),
                    1'($urandom_range(0, 1)));
        end else if (r < 92) begin
          drain();
        end else begin
          // a stray element with no last mark folds into the next vector
          send_element(pick_elem(), pick_value(), 1'b0);
        end
      end
      send_element(pick_elem(), pick_value(), 1'b1);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // let the final edge's scoreboard update land before reading it
    @(negedge clk);
    if (pending != 0) $error("%0d result beats never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: many times the slowest legal run
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
design/lsh_pkg.sv
design/lsh_ctrl.sv
design/lsh_dp.sv
design/hyperplane_lsh_signature.sv
tb/hyperplane_lsh_signature_checker.sv
tb/hyperplane_lsh_signature_tb.sv
